### rtl/core/base64_stream_encoder_defines.svh
// Assertion macros shared by the Base64 encoder RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B64E_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("Base64 encoder check failed.");

// The consequent must hold in the cycle after the antecedent.
`define B64E_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("Base64 encoder check failed.");

`endif

### rtl/core/b64e_pkg.sv
// Types, constants and the symbol lookup for the Base64 stream encoder.
// Depends on nothing; used by all encoder modules.
package b64e_pkg;

    localparam int QDEPTH = 2;

    localparam logic [1:0] PHASE_0 = 2'd0;
    localparam logic [1:0] PHASE_1 = 2'd1;
    localparam logic [1:0] PHASE_2 = 2'd2;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic       pad;
        logic [5:0] idx;
    } slot_t;

    typedef struct packed {
        slot_t [3:0] slots;
        logic  [1:0] last_slot;
        logic        last;
    } cmd_t;

    function automatic logic [7:0] sym_char(input slot_t s);
        logic [7:0] v;
        v = {2'b00, s.idx};
        if (s.pad) begin
            return PAD_CHAR;
        end else if (s.idx < 6'd26) begin
            return 8'(8'd65 + v);
        end else if (s.idx < 6'd52) begin
            return 8'(8'd71 + v);
        end else if (s.idx < 6'd62) begin
            return 8'(v - 8'd4);
        end else if (s.idx == 6'd62) begin
            return 8'h2B;
        end else begin
            return 8'h2F;
        end
    endfunction

endpackage

### rtl/core/b64e_front.sv
// Front end of the Base64 encoder: accepts bytes, tracks the group position
// and the held bits, and turns each byte into a character command.
// Depends on b64e_pkg.
`include "base64_stream_encoder_defines.svh"

module b64e_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_data_byte,
    input  logic            s_end_of_message,
    input  logic            q_full,
    output logic            q_push,
    output b64e_pkg::cmd_t  q_cmd
);

    logic [1:0] phase_reg, phase_next;
    logic [3:0] left_reg, left_next;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_cmd      = '0;
        phase_next = phase_reg;
        left_next  = left_reg;
        case (phase_reg)
            b64e_pkg::PHASE_1: begin
                q_cmd.slots[0].idx = {left_reg[1:0], s_data_byte[7:4]};
                q_cmd.slots[1].idx = {s_data_byte[3:0], 2'b00};
                q_cmd.slots[2].pad = 1'b1;
                q_cmd.last_slot    = s_end_of_message ? 2'd2 : 2'd0;
                phase_next         = b64e_pkg::PHASE_2;
                left_next          = s_data_byte[3:0];
            end
            b64e_pkg::PHASE_2: begin
                q_cmd.slots[0].idx = {left_reg, s_data_byte[7:6]};
                q_cmd.slots[1].idx = s_data_byte[5:0];
                q_cmd.last_slot    = 2'd1;
                phase_next         = b64e_pkg::PHASE_0;
                left_next          = 4'd0;
            end
            default: begin
                q_cmd.slots[0].idx = s_data_byte[7:2];
                q_cmd.slots[1].idx = {s_data_byte[1:0], 4'b0000};
                q_cmd.slots[2].pad = 1'b1;
                q_cmd.slots[3].pad = 1'b1;
                q_cmd.last_slot    = s_end_of_message ? 2'd3 : 2'd0;
                phase_next         = b64e_pkg::PHASE_1;
                left_next          = {2'b00, s_data_byte[1:0]};
            end
        endcase
        q_cmd.last = s_end_of_message;
        if (s_end_of_message) begin
            phase_next = b64e_pkg::PHASE_0;
            left_next  = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= b64e_pkg::PHASE_0;
            left_reg  <= 4'd0;
        end else if (q_push) begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

    `B64E_ASSERT_SAME(a_phase_legal, aclk, aresetn, 1'b1, phase_reg != 2'd3)
    `B64E_ASSERT_SAME(a_left_clear_at_start, aclk, aresetn,
        phase_reg == b64e_pkg::PHASE_0, left_reg == 4'd0)
    `B64E_ASSERT_SAME(a_left_two_bits, aclk, aresetn,
        phase_reg == b64e_pkg::PHASE_1, left_reg[3:2] == 2'b00)

endmodule

### rtl/core/b64e_queue.sv
// Short command queue between the encoder front end and back end.
// Depends on b64e_pkg.
`include "base64_stream_encoder_defines.svh"

module b64e_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  b64e_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            q_valid,
    output b64e_pkg::cmd_t  q_cmd
);

    localparam int PW = (b64e_pkg::QDEPTH > 1) ? $clog2(b64e_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(b64e_pkg::QDEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(b64e_pkg::QDEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(b64e_pkg::QDEPTH);

    b64e_pkg::cmd_t  entry_reg [b64e_pkg::QDEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign full    = count_reg == CNT_FULL;
    assign q_valid = count_reg != '0;
    assign q_cmd   = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : PW'(wr_ptr_reg + 1'b1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : PW'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop) begin
                count_reg <= CW'(count_reg + 1'b1);
            end else if (do_pop && !do_push) begin
                count_reg <= CW'(count_reg - 1'b1);
            end
        end
    end

    `B64E_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_FULL)

endmodule

### rtl/core/b64e_back.sv
// Back end of the Base64 encoder: takes character commands from the queue
// and emits one character per cycle, while m_ready allows, through a registered output.
// Depends on b64e_pkg.
`include "base64_stream_encoder_defines.svh"

module b64e_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    input  b64e_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      m_out_char,
    output logic            m_last_char
);

    b64e_pkg::cmd_t cmd_reg;
    logic           busy_reg;
    logic [1:0]     slot_reg;
    logic           valid_reg;
    logic [7:0]     char_reg;
    logic           last_reg;
    logic           emit, done;

    assign emit  = busy_reg && (!valid_reg || m_ready);
    assign done  = emit && (slot_reg == cmd_reg.last_slot);
    assign q_pop = q_valid && (!busy_reg || done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            slot_reg <= 2'd0;
        end else if (q_pop) begin
            busy_reg <= 1'b1;
            slot_reg <= 2'd0;
        end else if (done) begin
            busy_reg <= 1'b0;
        end else if (emit) begin
            slot_reg <= 2'(slot_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (emit) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            char_reg <= b64e_pkg::sym_char(cmd_reg.slots[slot_reg]);
            last_reg <= cmd_reg.last && done;
        end
    end

    assign m_valid     = valid_reg;
    assign m_out_char  = char_reg;
    assign m_last_char = last_reg;

    `B64E_ASSERT_SAME(a_slot_in_range, aclk, aresetn, busy_reg, slot_reg <= cmd_reg.last_slot)
    `B64E_ASSERT_NEXT(a_idle_after_done, aclk, aresetn, done && !q_pop, !busy_reg)

endmodule

### rtl/core/base64_stream_encoder.sv
// Top level of the Base64 stream encoder (standard alphabet, '=' padding).
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
// Bytes enter on the s_ channel and Base64 characters leave on the m_ channel,
// one character per cycle while m_ready allows. A byte yields one or two
// characters, so a full three-byte group yields four characters. A byte
// marked end_of_message yields up to four characters, the last one flagged by
// m_last_char. The output character register sets the rate; a two-entry
// command queue lets the input keep accepting while characters drain. A byte's
// command is registered in the queue and then in the back-end command register.
module base64_stream_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_message,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_last_char
);

    b64e_pkg::cmd_t push_cmd;
    b64e_pkg::cmd_t head_cmd;
    logic           q_full, q_push, q_valid, q_pop;

    b64e_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_end_of_message (s_end_of_message),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_cmd            (push_cmd)
    );

    b64e_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_cmd    (head_cmd)
    );

    b64e_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_last_char (m_last_char)
    );

endmodule
